[sv/subtitle_section_header_parser_defines.svh]
// Assertion macros shared by the subtitle section header parser.
`ifndef SUBTITLE_SECTION_HEADER_PARSER_DEFINES_SVH
`define SUBTITLE_SECTION_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication on clock, held off during reset.
`define SSHP_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sshp assertion failed");

// Next-cycle implication on clock, held off during reset.
`define SSHP_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sshp assertion failed");

`endif

[sv/sshp_pkg.sv]
// Types, codes and the CRC-32 byte step for the subtitle section header parser.
package sshp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_section;
      logic       last_of_buffer;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic        is_last;
      logic [1:0]  status;
      logic        overlay_present;
      logic [5:0]  proto_ver;
      logic [15:0] tbl_ext;
      logic [11:0] final_seg_num;
      logic [11:0] seg_num;
      logic [31:0] received_crc;
      logic        crc_ok;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] match_id;
      logic       accept_zero_crc;
   } cfg_type;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_ACTIVE,
      PHASE_BADLEN
   } phase_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_ID   = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic CSR_MATCH_ID        = 1'b0;
   localparam logic CSR_ACCEPT_ZERO_CRC = 1'b1;

   localparam logic [7:0]  MATCH_ID_RESET     = 8'hC6;
   localparam logic [11:0] MIN_SECTION_LENGTH = 12'd10;
   localparam logic [31:0] CRC_POLY           = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT           = 32'hFFFFFFFF;

   function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      c = acc ^ {24'h000000, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[sv/subtitle_section_header_parser.sv]
// Subtitle section header parser top level.
// A byte goes from the input register through the combinational parse core into the result register.
// Throughput: one byte per cycle while the response is not stalled; the parse state updates once per byte.
// A stalled result holds the byte stage; no other wait exists.
// Synchronous reset idles the parse state, presets the CRC, clears both valid flags and loads the CSR defaults.
`include "subtitle_section_header_parser_defines.svh"

module subtitle_section_header_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  sshp_pkg::req_item_type req_data,
   output logic                   req_stall,
   output logic                   rsp_valid,
   output sshp_pkg::rsp_item_type rsp_data,
   input  logic                   rsp_stall,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [7:0]             csr_wr_data
);
   import sshp_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         item_valid;
   req_item_type item;
   logic         out_ready;
   logic         fire;
   logic         res_valid;
   rsp_item_type res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MATCH_ID:        cfg_in.match_id        = csr_wr_data;
            CSR_ACCEPT_ZERO_CRC: cfg_in.accept_zero_crc = csr_wr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_id        <= MATCH_ID_RESET;
         cfg_ff.accept_zero_crc <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign fire = item_valid && out_ready;

   sshp_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .take       (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   sshp_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fire      (fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   sshp_output_reg u_output_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_item  (res),
      .ready      (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

   `SSHP_ASSERT_IMP(a_stall_needs_item, req_stall, item_valid)
   `SSHP_ASSERT_IMP(a_result_from_fire, res_valid, fire)
   `SSHP_ASSERT_NXT(a_fire_loads_result, fire && res_valid, rsp_valid && rsp_data == $past(res))
   `SSHP_ASSERT_IMP(a_crc_ok_clean, rsp_valid && rsp_data.crc_ok, rsp_data.status == STATUS_OK)
endmodule

[sv/sshp_input_reg.sv]
// Input register stage holding one request beat.
module sshp_input_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  sshp_pkg::req_item_type req_data,
   output logic                  req_stall,
   input  logic                  take,
   output logic                  item_valid,
   output sshp_pkg::req_item_type item
);
   import sshp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign req_stall = valid_ff && !take;
   assign valid_in  = req_stall ? 1'b1 : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

[sv/sshp_parse_core.sv]
// Section parse state and per-byte header, payload and CRC logic.
module sshp_parse_core (
   input  logic                   clock,
   input  logic                   reset,
   input  sshp_pkg::cfg_type      cfg,
   input  logic                   fire,
   input  sshp_pkg::req_item_type item,
   output logic                   res_valid,
   output sshp_pkg::rsp_item_type res
);
   import sshp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [12:0] pos_ff, pos_in;
   logic [11:0] len_ff, len_in;
   logic        ovl_ff, ovl_in;
   logic [5:0]  ver_ff, ver_in;
   logic [15:0] ext_ff, ext_in;
   logic [23:0] seg_ff, seg_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcv_ff, rcv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         ovl_ff   <= 1'b0;
         ver_ff   <= '0;
         ext_ff   <= '0;
         seg_ff   <= '0;
         crc_ff   <= CRC_INIT;
         rcv_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         ovl_ff   <= ovl_in;
         ver_ff   <= ver_in;
         ext_ff   <= ext_in;
         seg_ff   <= seg_in;
         crc_ff   <= crc_in;
         rcv_ff   <= rcv_in;
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [12:0] p;
      logic [13:0] p_inc;
      logic [13:0] len_old14;
      logic [13:0] len_p2;
      logic [12:0] start;
      logic        closed;
      logic        summ;
      logic [1:0]  summ_status;
      logic        summ_ok;
      logic        payload;

      b           = item.data_byte;
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      ovl_in      = ovl_ff;
      ver_in      = ver_ff;
      ext_in      = ext_ff;
      seg_in      = seg_ff;
      crc_in      = crc_ff;
      rcv_in      = rcv_ff;
      closed      = 1'b0;
      summ        = 1'b0;
      summ_status = STATUS_OK;
      summ_ok     = 1'b0;
      payload     = 1'b0;
      start       = 13'd4;
      len_p2      = '0;
      res_valid   = 1'b0;
      res         = '0;

      if (fire && item.first_of_section) begin
         phase_in = PHASE_ACTIVE;
         pos_in   = '0;
         len_in   = '0;
         ovl_in   = 1'b0;
         ver_in   = '0;
         ext_in   = '0;
         seg_in   = '0;
         crc_in   = CRC_INIT;
         rcv_in   = '0;
      end

      p         = pos_in;
      p_inc     = {1'b0, p} + 14'd1;
      len_old14 = {2'b00, len_in};

      if (fire && phase_in != PHASE_IDLE) begin
         if (phase_in == PHASE_ACTIVE && (p < 13'd3 || p_inc < len_old14)) begin
            crc_in = crc32_byte(crc_in, b);
         end

         if (p == 13'd0) begin
            if (b != cfg.match_id) begin
               summ        = 1'b1;
               closed      = 1'b1;
               summ_status = STATUS_BAD_ID;
            end
         end else if (p == 13'd1) begin
            len_in = {b[3:0], 8'h00};
         end else if (p == 13'd2) begin
            len_in = {len_in[11:8], b};
            if (len_in < MIN_SECTION_LENGTH) begin
               phase_in = PHASE_BADLEN;
            end
         end else if (p == 13'd3) begin
            ovl_in = b[6];
            ver_in = b[5:0];
         end else if (ovl_in && p <= 13'd8) begin
            if (p == 13'd4) begin
               ext_in = {b, 8'h00};
            end else if (p == 13'd5) begin
               ext_in = {ext_in[15:8], b};
            end else begin
               seg_in = {seg_in[15:0], b};
            end
         end

         len_p2 = {2'b00, len_in} + 14'd2;
         start  = ovl_in ? 13'd9 : 13'd4;

         if (!closed) begin
            if (phase_in == PHASE_BADLEN) begin
               if ({1'b0, p} >= len_p2) begin
                  summ        = 1'b1;
                  closed      = 1'b1;
                  summ_status = STATUS_BAD_LEN;
               end
            end else if (p >= 13'd3 && p_inc >= {2'b00, len_in}) begin
               rcv_in = {rcv_in[23:0], b};
               if ({1'b0, p} == len_p2) begin
                  summ        = 1'b1;
                  closed      = 1'b1;
                  summ_status = STATUS_OK;
                  summ_ok     = (rcv_in == ~crc_in) ||
                                (cfg.accept_zero_crc && rcv_in == 32'h0);
               end
            end else if (p >= start) begin
               payload = 1'b1;
            end
         end

         if (!closed) begin
            if (item.last_of_buffer) begin
               summ        = 1'b1;
               summ_status = STATUS_TRUNCATED;
            end else begin
               pos_in = p_inc[12:0];
            end
         end

         if (summ) begin
            phase_in            = PHASE_IDLE;
            res_valid           = 1'b1;
            res.kind            = KIND_SUMMARY;
            res.is_last         = 1'b1;
            res.status          = summ_status;
            res.overlay_present = ovl_in;
            res.proto_ver       = ver_in;
            res.tbl_ext         = ext_in;
            res.final_seg_num   = seg_in[23:12];
            res.seg_num         = seg_in[11:0];
            res.received_crc    = rcv_in;
            res.crc_ok          = summ_ok;
         end else if (payload) begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = b;
         end
      end
   end
endmodule

[sv/sshp_output_reg.sv]
// Result register driving the response channel.
module sshp_output_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   input  sshp_pkg::rsp_item_type load_item,
   output logic                   ready,
   output logic                   rsp_valid,
   output sshp_pkg::rsp_item_type rsp_data,
   input  logic                   rsp_stall
);
   import sshp_pkg::*;

   logic         valid_ff;
   rsp_item_type data_ff;

   assign ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && load_valid) begin
         data_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule
